FILE: hw/rtl/pkci_pkg.sv
package pkci_pkg;

  localparam int unsigned RingDepth = 64;
  localparam int unsigned RingAw    = $clog2(RingDepth);
  localparam int unsigned MaxKeys   = 64;
  localparam int unsigned QDepth    = 2;
  localparam int unsigned QAw       = $clog2(QDepth);

  typedef enum logic [2:0] {
    OP_EVENT   = 3'd0,
    OP_BTN_RD  = 3'd1,
    OP_POS_RD  = 3'd2,
    OP_POS_WR  = 3'd3,
    OP_KEY_RD  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    EV_MOVE   = 3'd0,
    EV_LEFT   = 3'd1,
    EV_MIDDLE = 3'd2,
    EV_RIGHT  = 3'd3,
    EV_CHAR   = 3'd4
  } ev_e;

  typedef enum logic [1:0] {
    REG_NORM_W = 2'd0,
    REG_NORM_H = 2'd1,
    REG_WIN_W  = 2'd2,
    REG_WIN_H  = 2'd3
  } reg_e;

  // request handed from the front to the back
  typedef struct packed {
    logic [2:0]  op;
    logic [2:0]  kind;
    logic        down;
    logic [11:0] px;
    logic [11:0] py;
    logic [6:0]  ch;
    logic [2:0]  sel;
    logic [14:0] set_x;
    logic [14:0] set_y;
    logic [6:0]  count;
  } req_t;

  typedef struct packed {
    logic        button_hit;
    logic [2:0]  sticky_buttons;
    logic [2:0]  button_levels;
    logic [15:0] norm_x;
    logic [15:0] norm_y;
    logic [11:0] window_x;
    logic [11:0] window_y;
    logic [6:0]  char_out;
    logic        char_valid;
    logic        last;
  } res_t;

endpackage

FILE: hw/rtl/pkci_div.sv
// unsigned 27/15 restoring divider, one quotient bit per cycle
module pkci_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [26:0] num_i,
  input  logic [14:0] den_i,
  output logic        done_o,
  output logic [26:0] quo_o
);
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [26:0] quo_q, quo_d;
  logic [15:0] rem_q, rem_d;
  logic [14:0] den_q, den_d;
  logic [15:0] trial;

  assign trial  = {rem_q[14:0], quo_q[26]};
  assign done_o = busy_q && (cnt_q == 5'd0);
  assign quo_o  = quo_q;

  always_comb begin
    cnt_d = cnt_q; busy_d = busy_q; quo_d = quo_q; rem_d = rem_q; den_d = den_q;
    if (start_i) begin
      busy_d = 1'b1; cnt_d = 5'd27; quo_d = num_i; rem_d = '0;
      den_d = (den_i == '0) ? 15'd1 : den_i;
    end else if (busy_q) begin
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 5'd1;
        if (trial >= {1'b0, den_q}) begin
          rem_d = trial - {1'b0, den_q};
          quo_d = {quo_q[25:0], 1'b1};
        end else begin
          rem_d = trial;
          quo_d = {quo_q[25:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d;
  end
endmodule

FILE: hw/rtl/pkci_front.sv
// accept requests, drop unknown operations, queue the rest in order for the back end
module pkci_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic [2:0]         operation_i,
  input  logic [2:0]         event_kind_i,
  input  logic               event_down_i,
  input  logic [11:0]        pointer_x_i,
  input  logic [11:0]        pointer_y_i,
  input  logic [6:0]         char_code_i,
  input  logic [2:0]         button_select_i,
  input  logic [14:0]        set_norm_x_i,
  input  logic [14:0]        set_norm_y_i,
  input  logic [6:0]         char_count_i,
  // queue to back end
  output logic               q_valid_o,
  output pkci_pkg::req_t     q_req_o,
  input  logic               q_pop_i
);
  pkci_pkg::req_t q_mem [pkci_pkg::QDepth];
  logic [pkci_pkg::QAw:0]   cnt_q, cnt_d;
  logic [pkci_pkg::QAw-1:0] rd_q, rd_d, wr_q, wr_d;
  logic                     acc, enq, deq;

  assign full_o    = (cnt_q == (pkci_pkg::QAw+1)'(pkci_pkg::QDepth));
  assign acc       = push_i && !full_o;
  assign enq       = acc && (operation_i == pkci_pkg::OP_EVENT ||
                     operation_i == pkci_pkg::OP_BTN_RD ||
                     operation_i == pkci_pkg::OP_POS_RD ||
                     operation_i == pkci_pkg::OP_POS_WR ||
                     operation_i == pkci_pkg::OP_KEY_RD);
  assign deq       = q_pop_i && q_valid_o;
  assign q_valid_o = (cnt_q != '0);
  assign q_req_o   = q_mem[rd_q];

  always_comb begin
    rd_d = rd_q; wr_d = wr_q;
    if (enq) begin
      wr_d = (wr_q == (pkci_pkg::QAw)'(pkci_pkg::QDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (deq) begin
      rd_d = (rd_q == (pkci_pkg::QAw)'(pkci_pkg::QDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    cnt_d = cnt_q + (pkci_pkg::QAw+1)'(enq) - (pkci_pkg::QAw+1)'(deq);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; rd_q <= '0; wr_q <= '0;
    end else begin
      cnt_q <= cnt_d; rd_q <= rd_d; wr_q <= wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      q_mem[wr_q] <= '{op: operation_i, kind: event_kind_i, down: event_down_i,
                       px: pointer_x_i, py: pointer_y_i, ch: char_code_i,
                       sel: button_select_i, set_x: set_norm_x_i,
                       set_y: set_norm_y_i, count: char_count_i};
    end
  end
endmodule

FILE: hw/rtl/pkci_back.sv
// carry out queued requests in order; owns pointer state and the key ring
module pkci_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [14:0]     norm_w_i,
  input  logic [14:0]     norm_h_i,
  input  logic [11:0]     win_w_i,
  input  logic [11:0]     win_h_i,
  input  logic            q_valid_i,
  input  pkci_pkg::req_t  q_req_i,
  output logic            q_pop_o,
  output logic            res_valid_o,
  output pkci_pkg::res_t  res_o,
  input  logic            res_pop_i
);
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MULX  = 9'b000000010,
    S_DIVX  = 9'b000000100,
    S_MULY  = 9'b000001000,
    S_DIVY  = 9'b000010000,
    S_DONE  = 9'b000100000,
    S_KEYRD = 9'b001000000,
    S_KEYEM = 9'b010000000,
    S_KEYWT = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic [11:0] wx_q, wx_d, wy_q, wy_d;
  logic [15:0] nx_q, nx_d, ny_q, ny_d;
  logic        moved_q, moved_d;
  logic [2:0]  press_q, press_d, level_q, level_d;
  logic [6:0]  ring [pkci_pkg::RingDepth];
  logic [pkci_pkg::RingAw-1:0] head_q, tail_q, tail_d;
  logic [pkci_pkg::RingAw:0]   fill_q, fill_d;
  logic [6:0]  left_q, left_d;
  pkci_pkg::req_t req_q, req_d;
  logic [26:0] prod_q, prod_d;
  logic        div_start, div_done;
  logic [14:0] div_den;
  logic [26:0] div_quo;
  logic        rv_q, rv_d;
  pkci_pkg::res_t r_q, r_d;
  logic [6:0]  ring_rd_q;
  logic        key_pop, key_wr, ring_full;
  logic [6:0]  want;
  logic [2:0]  bit_m;

  assign ring_full   = (fill_q == (pkci_pkg::RingAw+1)'(pkci_pkg::RingDepth));
  assign res_valid_o = rv_q;
  assign res_o       = r_q;
  assign want        = (q_req_i.count > 7'(pkci_pkg::MaxKeys)) ?
                       7'(pkci_pkg::MaxKeys) : q_req_i.count;

  pkci_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(prod_q), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  always_comb begin
    unique case (q_req_i.kind)
      pkci_pkg::EV_LEFT:   bit_m = 3'd4;
      pkci_pkg::EV_MIDDLE: bit_m = 3'd2;
      pkci_pkg::EV_RIGHT:  bit_m = 3'd1;
      default:             bit_m = 3'd0;
    endcase
  end

  always_comb begin
    state_d = state_q; wx_d = wx_q; wy_d = wy_q; nx_d = nx_q; ny_d = ny_q;
    moved_d = moved_q; press_d = press_q; level_d = level_q;
    tail_d = tail_q; fill_d = fill_q; left_d = left_q; req_d = req_q;
    prod_d = prod_q; div_start = 1'b0; div_den = 15'd1;
    rv_d = rv_q; r_d = r_q; q_pop_o = 1'b0; key_pop = 1'b0; key_wr = 1'b0;
    if (res_pop_i && rv_q) begin
      rv_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i && q_req_i.op == pkci_pkg::OP_EVENT) begin
          // events give no result, so take them even while a result waits
          q_pop_o = 1'b1;
          unique case (q_req_i.kind)
            pkci_pkg::EV_MOVE: begin
              wx_d = q_req_i.px; wy_d = q_req_i.py; moved_d = 1'b1;
            end
            pkci_pkg::EV_CHAR: begin
              key_wr = q_req_i.down && !ring_full;
            end
            default: begin
              if (q_req_i.down) begin
                press_d = press_q | bit_m;
                level_d = level_q | bit_m;
              end else begin
                level_d = level_q & ~bit_m;
              end
            end
          endcase
        end else if (q_valid_i && !rv_d) begin
          q_pop_o = 1'b1;
          req_d   = q_req_i;
          r_d     = '0;
          unique case (q_req_i.op)
            pkci_pkg::OP_BTN_RD: begin
              r_d.button_hit     = |(press_d & q_req_i.sel);
              r_d.sticky_buttons = press_d;
              r_d.button_levels  = level_d;
              r_d.last           = 1'b1;
              press_d = press_d & ~q_req_i.sel;
              rv_d    = 1'b1;
            end
            pkci_pkg::OP_POS_RD: begin
              if (moved_d) begin
                moved_d = 1'b0;
                prod_d  = 27'(wx_d) * 27'(norm_w_i);
                state_d = S_MULX;
              end else begin
                r_d.button_levels = level_d;
                r_d.norm_x = nx_q; r_d.norm_y = ny_q; r_d.last = 1'b1;
                rv_d = 1'b1;
              end
            end
            pkci_pkg::OP_POS_WR: begin
              nx_d = {1'b0, q_req_i.set_x};
              ny_d = {1'b0, q_req_i.set_y};
              prod_d  = 27'(q_req_i.set_x) * 27'(win_w_i);
              state_d = S_MULX;
            end
            default: begin
              if (fill_q == '0 || want == 7'd0) begin
                r_d.last = 1'b1; rv_d = 1'b1;
              end else begin
                left_d  = want;
                state_d = S_KEYRD;
              end
            end
          endcase
        end
      end
      S_MULX: begin
        div_start = 1'b1;
        div_den   = (req_q.op == pkci_pkg::OP_POS_RD) ? {3'd0, win_w_i} : norm_w_i;
        state_d   = S_DIVX;
      end
      S_DIVX: begin
        if (div_done) begin
          if (req_q.op == pkci_pkg::OP_POS_RD) begin
            nx_d   = (div_quo > 27'd32767) ? 16'd32767 : div_quo[15:0];
            prod_d = 27'(wy_q) * 27'(norm_h_i);
          end else begin
            wx_d   = (div_quo > 27'd4095) ? 12'd4095 : div_quo[11:0];
            // norm_height - ny may be negative: divide magnitude, sign later
            prod_d = (norm_h_i >= req_q.set_y) ?
                     27'(norm_h_i - req_q.set_y) * 27'(win_h_i) :
                     27'(req_q.set_y - norm_h_i) * 27'(win_h_i);
          end
          state_d = S_MULY;
        end
      end
      S_MULY: begin
        div_start = 1'b1;
        div_den   = (req_q.op == pkci_pkg::OP_POS_RD) ? {3'd0, win_h_i} : norm_h_i;
        state_d   = S_DIVY;
      end
      S_DIVY: begin
        if (div_done) begin
          if (req_q.op == pkci_pkg::OP_POS_RD) begin
            // nh - q, q >= 0, nh < 2^15: saturate low only
            if ({12'd0, norm_h_i} >= div_quo) begin
              ny_d = {1'b0, 15'(norm_h_i - div_quo[14:0])};
            end else if (div_quo - {12'd0, norm_h_i} > 27'd32768) begin
              ny_d = 16'h8000;
            end else begin
              ny_d = 16'(17'd0 - 17'(div_quo - {12'd0, norm_h_i}));
            end
          end else if (norm_h_i < req_q.set_y) begin
            wy_d = 12'd0;
          end else begin
            wy_d = (div_quo > 27'd4095) ? 12'd4095 : div_quo[11:0];
          end
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!rv_d) begin
          r_d = '0;
          r_d.norm_x = nx_q; r_d.norm_y = ny_q; r_d.last = 1'b1;
          if (req_q.op == pkci_pkg::OP_POS_RD) begin
            r_d.button_levels = level_q;
          end else begin
            r_d.window_x = wx_q; r_d.window_y = wy_q;
          end
          rv_d = 1'b1; state_d = S_IDLE;
        end
      end
      S_KEYRD: begin
        if (!rv_d) begin
          key_pop = 1'b1;
          r_d = '0;
          r_d.char_out = ring_rd_q; r_d.char_valid = 1'b1;
          r_d.last = (left_q == 7'd1) || (fill_q == (pkci_pkg::RingAw+1)'(1));
          rv_d   = 1'b1;
          tail_d = (tail_q == (pkci_pkg::RingAw)'(pkci_pkg::RingDepth - 1)) ?
                   '0 : tail_q + 1'b1;
          left_d = left_q - 7'd1;
          state_d = r_d.last ? S_IDLE : S_KEYRD;
        end
      end
      S_KEYEM: state_d = S_IDLE;
      S_KEYWT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    fill_d = fill_q + (pkci_pkg::RingAw+1)'(key_wr) - (pkci_pkg::RingAw+1)'(key_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; wx_q <= '0; wy_q <= '0; nx_q <= '0; ny_q <= '0;
      moved_q <= 1'b0; press_q <= '0; level_q <= '0;
      head_q <= '0; tail_q <= '0; fill_q <= '0; rv_q <= 1'b0;
    end else begin
      state_q <= state_d; wx_q <= wx_d; wy_q <= wy_d; nx_q <= nx_d; ny_q <= ny_d;
      moved_q <= moved_d; press_q <= press_d; level_q <= level_d;
      tail_q <= tail_d; fill_q <= fill_d; rv_q <= rv_d;
      if (key_wr) begin
        head_q <= (head_q == (pkci_pkg::RingAw)'(pkci_pkg::RingDepth - 1)) ?
                  '0 : head_q + 1'b1;
      end
    end
  end

  // register the ring read at the next tail, so the next character is ready ahead of its use
  always_ff @(posedge clk_i) begin
    left_q <= left_d; req_q <= req_d; prod_q <= prod_d; r_q <= r_d;
    ring_rd_q <= ring[tail_d];
    if (key_wr) begin
      ring[head_q] <= q_req_i.ch;
    end
  end
endmodule

FILE: hw/rtl/pointer_and_key_input_controller.sv
// Channel   | Direction | Handshake    | Payload
// ----------+-----------+--------------+------------------------------------------
// request   | in        | push/full    | operation, event, pointer, key, set, count
// result    | out       | pop/empty    | buttons, normalized and window position,
//           |           |              | character, last
// config    | in        | cfg_we_i     | cfg_index_i, cfg_data_i (no read-back)
//
// Every known request passes through a two-deep queue in order (unknown operations
// are dropped); an event takes effect once the back end pops it and gives no result.
// A button read or an empty key read has its result registered when popped; a
// position read after a move and a position write run the bit-serial divider
// twice, for x and then for y. A key read gives its first character from the
// ring, then one a cycle while pop keeps up. Reset clears all pointer, button and
// ring control state; the ring's character store is not cleared. Events keep
// draining from the queue while a result waits and the back end is idle; any
// other request holds in the queue until the result is taken.
module pointer_and_key_input_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  operation_i,
  input  logic [2:0]  event_kind_i,
  input  logic        event_down_i,
  input  logic [11:0] pointer_x_i,
  input  logic [11:0] pointer_y_i,
  input  logic [6:0]  char_code_i,
  input  logic [2:0]  button_select_i,
  input  logic [14:0] set_norm_x_i,
  input  logic [14:0] set_norm_y_i,
  input  logic [6:0]  char_count_i,
  output logic        empty,
  input  logic        pop,
  output logic        button_hit_o,
  output logic [2:0]  sticky_buttons_o,
  output logic [2:0]  button_levels_o,
  output logic signed [15:0] norm_x_o,
  output logic signed [15:0] norm_y_o,
  output logic [11:0] window_x_o,
  output logic [11:0] window_y_o,
  output logic [6:0]  char_out_o,
  output logic        char_valid_o,
  output logic        last_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [14:0] cfg_data_i
);
  logic [14:0] norm_w_q, norm_h_q;
  logic [11:0] win_w_q, win_h_q;
  logic        q_valid, q_pop, res_valid;
  pkci_pkg::req_t q_req;
  pkci_pkg::res_t res;

  // hold configuration; index picks the register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      norm_w_q <= 15'd32767; norm_h_q <= 15'd32767;
      win_w_q  <= 12'd1024;  win_h_q  <= 12'd1024;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pkci_pkg::REG_NORM_W: norm_w_q <= cfg_data_i;
        pkci_pkg::REG_NORM_H: norm_h_q <= cfg_data_i;
        pkci_pkg::REG_WIN_W:  win_w_q  <= cfg_data_i[11:0];
        default:              win_h_q  <= cfg_data_i[11:0];
      endcase
    end
  end

  pkci_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full),
    .operation_i, .event_kind_i, .event_down_i, .pointer_x_i, .pointer_y_i,
    .char_code_i, .button_select_i, .set_norm_x_i, .set_norm_y_i, .char_count_i,
    .q_valid_o(q_valid), .q_req_o(q_req), .q_pop_i(q_pop)
  );

  pkci_back u_back (
    .clk_i, .rst_ni, .norm_w_i(norm_w_q), .norm_h_i(norm_h_q),
    .win_w_i(win_w_q), .win_h_i(win_h_q),
    .q_valid_i(q_valid), .q_req_i(q_req), .q_pop_o(q_pop),
    .res_valid_o(res_valid), .res_o(res), .res_pop_i(pop)
  );

  assign empty            = !res_valid;
  assign button_hit_o     = res.button_hit;
  assign sticky_buttons_o = res.sticky_buttons;
  assign button_levels_o  = res.button_levels;
  assign norm_x_o         = res.norm_x;
  assign norm_y_o         = res.norm_y;
  assign window_x_o       = res.window_x;
  assign window_y_o       = res.window_y;
  assign char_out_o       = res.char_out;
  assign char_valid_o     = res.char_valid;
  assign last_o           = res.last;
endmodule
